// ===== hw/rtl/smu_pkg.sv =====
// Shared types and codes for the sorted merge union block.
package smu_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_RUN    = 2'd2,
        CMD_NOP    = 2'd3
    } smu_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_PICK  = 4'b0100,
        ST_FINAL = 4'b1000
    } smu_state_t;

    // Decision of the select unit for one merge step.
    typedef struct packed {
        logic any;       // at least one list still has elements
        logic take_a;    // the element comes from the first list
        logic emit_new;  // the element differs from the one held back, or none is held
    } smu_pick_t;

endpackage

// ===== hw/rtl/smu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smu_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 16,
        localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic                     aclk,
        input  logic                     we,
        input  logic [AW-1:0]            waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [AW-1:0]            raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/smu_sel.sv =====
// Compare and select unit used once per merge step.
module smu_sel
    import smu_pkg::*;
    #(
        parameter int DATA_WIDTH = 32
    )
    (
        input  logic signed [DATA_WIDTH-1:0] a_val,
        input  logic signed [DATA_WIDTH-1:0] b_val,
        input  logic                         a_avail,
        input  logic                         b_avail,
        input  logic signed [DATA_WIDTH-1:0] prev_val,
        input  logic                         have_prev,
        output smu_pick_t                    pick,
        output logic signed [DATA_WIDTH-1:0] sel_val
    );

    logic a_le_b;

    // Ties go to the first list.
    assign a_le_b = (a_val <= b_val);

    always_comb begin
        pick.any      = a_avail || b_avail;
        pick.take_a   = a_avail && (!b_avail || a_le_b);
        sel_val       = pick.take_a ? a_val : b_val;
        pick.emit_new = !have_prev || (sel_val != prev_val);
    end

endmodule

// ===== hw/rtl/sorted_merge_union.sv =====
// A load transaction is taken while idle and gives no result.
// A run walks both stores element by element, each step a RAM read (FETCH)
// then a compare (PICK); a step stalls in PICK while the output is held.
// The block is not ready for input while a run is in progress.
// Reset clears the counts, the dropped flag, the sequencer and the output
// valid flag; the stores keep their contents and are read only below the counts.
module sorted_merge_union
    import smu_pkg::*;
    #(
        parameter int DEPTH      = 16,
        parameter int DATA_WIDTH = 32
    )
    (
        input  logic                         aclk,
        input  logic                         aresetn,
        input  logic                         s_valid,
        output logic                         s_ready,
        input  logic [1:0]                   s_command,
        input  logic signed [DATA_WIDTH-1:0] s_value,
        output logic                         m_valid,
        input  logic                         m_ready,
        output logic signed [DATA_WIDTH-1:0] m_value_res,
        output logic                         m_last,
        output logic                         m_empty_res,
        output logic                         m_overflow
    );

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    smu_state_t state_reg, state_next;

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          dropped_reg, dropped_next;
    logic          have_prev_reg, have_prev_next;
    logic signed [DATA_WIDTH-1:0] prev_reg, prev_next;

    logic                         m_valid_reg, m_valid_next;
    logic signed [DATA_WIDTH-1:0] m_value_reg, m_value_next;
    logic                         m_last_reg, m_last_next;
    logic                         m_empty_reg, m_empty_next;
    logic                         m_ovf_reg, m_ovf_next;

    logic                         s_fire;
    logic                         we_a, we_b;
    logic                         out_free;
    logic signed [DATA_WIDTH-1:0] rd_a, rd_b;
    logic signed [DATA_WIDTH-1:0] sel_val;
    smu_pick_t                    pick;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign we_a     = s_fire && (s_command == CMD_LOAD_A) && (cnt_a_reg < CW'(DEPTH));
    assign we_b     = s_fire && (s_command == CMD_LOAD_B) && (cnt_b_reg < CW'(DEPTH));

    smu_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata (s_value),
        .raddr (i_reg[AW-1:0]),
        .rdata (rd_a)
    );

    smu_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata (s_value),
        .raddr (j_reg[AW-1:0]),
        .rdata (rd_b)
    );

    smu_sel #(.DATA_WIDTH(DATA_WIDTH)) u_sel (
        .a_val     (rd_a),
        .b_val     (rd_b),
        .a_avail   (i_reg < cnt_a_reg),
        .b_avail   (j_reg < cnt_b_reg),
        .prev_val  (prev_reg),
        .have_prev (have_prev_reg),
        .pick      (pick),
        .sel_val   (sel_val)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        dropped_next   = dropped_reg;
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_value_next   = m_value_reg;
        m_last_next    = m_last_reg;
        m_empty_next   = m_empty_reg;
        m_ovf_next     = m_ovf_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_command)
                        CMD_LOAD_A: begin
                            if (we_a) begin
                                cnt_a_next = cnt_a_reg + CW'(1);
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        CMD_LOAD_B: begin
                            if (we_b) begin
                                cnt_b_next = cnt_b_reg + CW'(1);
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        CMD_RUN: begin
                            i_next         = '0;
                            j_next         = '0;
                            have_prev_next = 1'b0;
                            state_next     = ST_FETCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // The read addresses settle here; data is valid next cycle.
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (!pick.any) begin
                    state_next = ST_FINAL;
                end else if (!(pick.emit_new && have_prev_reg && !out_free)) begin
                    if (pick.take_a) begin
                        i_next = i_reg + CW'(1);
                    end else begin
                        j_next = j_reg + CW'(1);
                    end
                    if (pick.emit_new) begin
                        // The held value is now known not to be the final one.
                        if (have_prev_reg) begin
                            m_valid_next = 1'b1;
                            m_value_next = prev_reg;
                            m_last_next  = 1'b0;
                            m_empty_next = 1'b0;
                            m_ovf_next   = dropped_reg;
                        end
                        prev_next      = sel_val;
                        have_prev_next = 1'b1;
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = have_prev_reg ? prev_reg : '0;
                    m_last_next  = 1'b1;
                    m_empty_next = !have_prev_reg;
                    m_ovf_next   = dropped_reg;
                    cnt_a_next   = '0;
                    cnt_b_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            dropped_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            dropped_reg   <= dropped_next;
            have_prev_reg <= have_prev_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg    <= prev_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
        m_empty_reg <= m_empty_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_value_res = m_value_reg;
    assign m_last      = m_last_reg;
    assign m_empty_res = m_empty_reg;
    assign m_overflow  = m_ovf_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_a_reg <= CW'(DEPTH)) && (cnt_b_reg <= CW'(DEPTH)))
        else $error("list count beyond depth");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK) |-> (i_reg <= cnt_a_reg) && (j_reg <= cnt_b_reg))
        else $error("merge pointer beyond list count");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_empty_res) |-> (m_last && (m_value_res == '0)))
        else $error("empty result not final or not zero");

    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_command == CMD_RUN)) |=> (state_reg == ST_FETCH) && !have_prev_reg)
        else $error("run did not start a merge");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the sorted merge union block.
`timescale 1ns / 1ps

module tb;
    import smu_pkg::*;

    localparam int DEPTH = 16;
    localparam int DW    = 32;

    typedef logic signed [DW-1:0] data_t;

    typedef struct packed {
        logic [DW-1:0] value;
        logic          last;
        logic          empty;
        logic          ovf;
    } union_result_t;

    typedef struct {
        smu_cmd_t      cmd;
        data_t         value;
        bit            typed;
        union_result_t want;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_NOP;
    data_t       s_value   = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    data_t       m_value_res;
    logic        m_last;
    logic        m_empty_res;
    logic        m_overflow;

    // Predictor state: the two stores, their fill levels and the drop flag.
    data_t store_a [DEPTH];
    data_t store_b [DEPTH];
    int    count_a = 0;
    int    count_b = 0;
    bit    dropped = 1'b0;

    union_result_t union_expected[$];
    union_result_t run_results[$];
    union_result_t want;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_ask     = 0;
    int hold_left    = 0;

    int mismatch_count   = 0;
    int useful_items     = 0;
    int runs_done        = 0;
    int empty_runs       = 0;
    int overflow_runs    = 0;
    int results_checked  = 0;
    int input_stalls     = 0;

    // Hand-checked rows carry their result; the others go through the predictor.
    stim_row_t directed_rows [21] = '{
        '{CMD_RUN,    0,             1'b1, '{0, 1'b1, 1'b1, 1'b0}},
        '{CMD_NOP,    32'h5555_5555, 1'b0, '0},
        '{CMD_LOAD_A, 32'h8000_0000, 1'b0, '0},
        '{CMD_LOAD_A, -5,            1'b0, '0},
        '{CMD_LOAD_A, 7,             1'b0, '0},
        '{CMD_LOAD_A, 32'h7fff_ffff, 1'b0, '0},
        '{CMD_LOAD_B, -5,            1'b0, '0},
        '{CMD_LOAD_B, 0,             1'b0, '0},
        '{CMD_LOAD_B, 32'h7fff_ffff, 1'b0, '0},
        '{CMD_RUN,    0,             1'b0, '0},
        '{CMD_LOAD_B, 3,             1'b0, '0},
        '{CMD_RUN,    32'hffff_ffff, 1'b0, '0},
        '{CMD_LOAD_A, 9,             1'b0, '0},
        '{CMD_LOAD_A, 9,             1'b0, '0},
        '{CMD_LOAD_A, 2,             1'b0, '0},
        '{CMD_LOAD_B, 1,             1'b0, '0},
        '{CMD_RUN,    0,             1'b0, '0},
        '{CMD_NOP,    32'haaaa_aaaa, 1'b0, '0},
        '{CMD_RUN,    0,             1'b1, '{0, 1'b1, 1'b1, 1'b0}},
        '{CMD_LOAD_B, 32'h7fff_ffff, 1'b0, '0},
        '{CMD_RUN,    0,             1'b1, '{32'h7fff_ffff, 1'b1, 1'b0, 1'b0}}
    };

    sorted_merge_union #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DW)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_res (m_value_res),
        .m_last      (m_last),
        .m_empty_res (m_empty_res),
        .m_overflow  (m_overflow)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 30) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Applies one accepted transaction to the predictor; a run leaves its
    // union in run_results.
    task automatic predict_union(input smu_cmd_t cmd, input data_t val);
        data_t         merged[$];
        data_t         pick;
        union_result_t res;
        int            ia;
        int            ib;
        run_results.delete();
        case (cmd)
            CMD_LOAD_A: begin
                if (count_a < DEPTH) begin
                    store_a[count_a] = val;
                    count_a++;
                end else begin
                    dropped = 1'b1;
                end
            end
            CMD_LOAD_B: begin
                if (count_b < DEPTH) begin
                    store_b[count_b] = val;
                    count_b++;
                end else begin
                    dropped = 1'b1;
                end
            end
            CMD_RUN: begin
                ia = 0;
                ib = 0;
                while (ia < count_a || ib < count_b) begin
                    if (ib >= count_b || (ia < count_a && store_a[ia] <= store_b[ib])) begin
                        pick = store_a[ia];
                        ia++;
                    end else begin
                        pick = store_b[ib];
                        ib++;
                    end
                    if (merged.size() == 0 || merged[$] != pick) begin
                        merged.insert(merged.size(), pick);
                    end
                end
                runs_done++;
                if (dropped) begin
                    overflow_runs++;
                end
                if (merged.size() == 0) begin
                    empty_runs++;
                    run_results.insert(run_results.size(),
                                       union_result_t'{0, 1'b1, 1'b1, dropped});
                end
                for (int k = 0; k < merged.size(); k++) begin
                    res.value = merged[k];
                    res.last  = (k == merged.size() - 1);
                    res.empty = 1'b0;
                    res.ovf   = dropped;
                    run_results.insert(run_results.size(), res);
                end
                count_a = 0;
                count_b = 0;
                dropped = 1'b0;
            end
            default: ;
        endcase
        if (cmd != CMD_NOP) begin
            useful_items++;
        end
    endtask

    // Offers one transaction, waits for it to be taken and queues its results.
    task automatic send_item(input smu_cmd_t cmd, input data_t val,
                             input bit typed, input union_result_t typed_res);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= val;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_union(cmd, val);
        if (typed) begin
            union_expected.insert(union_expected.size(), typed_res);
        end else begin
            foreach (run_results[k]) begin
                union_expected.insert(union_expected.size(), run_results[k]);
            end
        end
    endtask

    // Loads two lists in random interleaving, with some ignored commands
    // mixed in, then asks for their union.
    task automatic send_merge_case(input int na, input int nb, input bit wide,
                                   input bit scrambled, input bit hold_output);
        data_t first_vals[$];
        data_t second_vals[$];
        data_t cur;
        for (int side = 0; side < 2; side++) begin
            if (wide) begin
                cur = data_t'(32'h8000_0000 + $urandom_range(0, 32'h4000_0000));
            end else begin
                cur = data_t'($urandom_range(0, 40)) - 20;
            end
            for (int k = 0; k < (side == 0 ? na : nb); k++) begin
                if (scrambled) begin
                    cur = $urandom;
                end else if (wide) begin
                    cur = cur + data_t'($urandom_range(0, 32'h0400_0000));
                end else begin
                    cur = cur + data_t'($urandom_range(0, 2));
                end
                if (side == 0) begin
                    first_vals.insert(first_vals.size(), cur);
                end else begin
                    second_vals.insert(second_vals.size(), cur);
                end
            end
        end
        while (first_vals.size() + second_vals.size() > 0) begin
            if ($urandom_range(11) == 0) begin
                send_item(CMD_NOP, $urandom, 1'b0, '0);
            end
            if (second_vals.size() == 0 ||
                (first_vals.size() != 0 && $urandom_range(1) == 0)) begin
                send_item(CMD_LOAD_A, first_vals.pop_front(), 1'b0, '0);
            end else begin
                send_item(CMD_LOAD_B, second_vals.pop_front(), 1'b0, '0);
            end
        end
        if (hold_output) begin
            hold_ask = 300;
        end
        send_item(CMD_RUN, $urandom, 1'b0, '0);
    endtask

    // The receiver either serves a requested long hold-off or stalls at random.
    always @(posedge aclk) begin
        if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && !s_ready) begin
                input_stalls++;
            end
            if (m_valid && m_ready) begin
                if (union_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, value %0d",
                                              m_value_res));
                end else begin
                    want = union_expected.pop_front();
                    results_checked++;
                    if (m_value_res !== want.value) begin
                        report_mismatch($sformatf("value_res got %0d, want %0d",
                                                  m_value_res, data_t'(want.value)));
                    end
                    if (m_last !== want.last) begin
                        report_mismatch($sformatf("last got %b, want %b",
                                                  m_last, want.last));
                    end
                    if (m_empty_res !== want.empty) begin
                        report_mismatch($sformatf("empty_res got %b, want %b",
                                                  m_empty_res, want.empty));
                    end
                    if (m_overflow !== want.ovf) begin
                        report_mismatch($sformatf("overflow got %b, want %b",
                                                  m_overflow, want.ovf));
                    end
                end
            end
        end
    end

    initial begin
        int phase_idle  [4];
        int phase_stall [4];
        int target;
        int na;
        int nb;
        bit first_case;
        phase_idle  = '{0, 58, 0, 7};
        phase_stall = '{0, 0, 58, 7};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].cmd, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].want);
        end

        first_case = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = phase_idle[phase];
            stall_pct = phase_stall[phase];
            target    = useful_items + 25;
            while (useful_items < target) begin
                if (first_case) begin
                    // The first store overfills and the second fills up while the output is held off.
                    send_merge_case(DEPTH + 2, DEPTH, 1'b1, 1'b0, 1'b1);
                    first_case = 1'b0;
                end else begin
                    na = ($urandom_range(4) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 3)
                                                  : $urandom_range(0, 5);
                    nb = ($urandom_range(4) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 3)
                                                  : $urandom_range(0, 5);
                    send_merge_case(na, nb, 1'($urandom_range(1)), $urandom_range(7) == 0,
                                    1'b0);
                end
            end
        end
        s_valid <= 1'b0;

        while (union_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (100) @(posedge aclk);

        $display("Sent %0d loads and runs: %0d runs, %0d with both lists empty, %0d after a drop.",
                 useful_items, runs_done, empty_runs, overflow_runs);
        $display("Checked %0d results; input was back-pressured for %0d cycles.",
                 results_checked, input_stalls);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
